/* src/lats_pkg.sv */
// ----------------------------------------------------------------------------
// lats_pkg
// Shared codes and types for the toroidal life automaton step core.
// ----------------------------------------------------------------------------
package lats_pkg;

	// Request operation codes
	typedef enum logic [2:0] {
		OP_SET_CELL   = 3'd0,
		OP_CLEAR_CELL = 3'd1,
		OP_READ_CELL  = 3'd2,
		OP_STEP_GEN   = 3'd3,
		OP_CLEAR_GRID = 3'd4
	} op_t;

	// Configuration register indexes
	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_COLS_IN_USE = 1'b1;

	localparam int unsigned CFG_WIDTH = 7;
	localparam logic [CFG_WIDTH-1:0] ROWS_RESET = 7'd64;
	localparam logic [CFG_WIDTH-1:0] COLS_RESET = 7'd64;

	// B3/S23 neighbour counts
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	// Controller states, one-hot
	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_ACC  = 7'b0000100,
		S_WIPE = 7'b0001000,
		S_STEP = 7'b0010000,
		S_LAST = 7'b0100000,
		S_TAIL = 7'b1000000
	} state_t;

endpackage

/* src/life_automaton_torus_step_core.sv */
// ----------------------------------------------------------------------------
// life_automaton_torus_step_core
// B3/S23 life automaton on a wrapping bit grid held one row per memory word.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears one cycle wide with done high and cannot be held off, so sample it
// on that cycle. An in-range set, clear or read does one memory read, then
// the write-back or the result. Out-of-range accesses, undefined codes and a
// step with no cells in use answer straight from idle, with no memory access.
// A generation step reads the two-port row memory once per row (plus one
// wrap row) into a three-row window, and each new row is written back as the
// window moves on. Clear-grid sweeps the memory one row a cycle. After reset
// busy stays high while the same sweep clears the grid; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_core #(
	parameter int unsigned MAX_ROWS = 64,
	parameter int unsigned MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	output logic        done,
	output logic        cell_value,
	output logic        in_range,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [lats_pkg::CFG_WIDTH-1:0] cfg_data
);

	localparam int unsigned RA  = $clog2(MAX_ROWS);
	localparam int unsigned CA  = $clog2(MAX_COLS);
	localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
	localparam int unsigned CCW = $clog2(MAX_COLS + 1);
	localparam logic [RA-1:0] LAST_ROW = RA'(MAX_ROWS - 1);

	typedef logic [MAX_COLS-1:0] row_word_t;

	lats_pkg::state_t state_q;

	logic [lats_pkg::CFG_WIDTH-1:0] rows_q, cols_q;
	logic [RCW-1:0] nr;
	logic [CCW-1:0] nc;
	logic [CA-1:0]  ncm1;

	logic [2:0]     op_q;
	logic [RA-1:0]  row_q;
	logic [CA-1:0]  col_q;
	logic [RA-1:0]  wc_q;
	logic [RCW-1:0] rk_q;
	logic           rv_s1;
	logic [RCW-1:0] rk_s1;
	logic           done_q, cell_value_q, in_range_q;

	row_word_t mem [MAX_ROWS];
	row_word_t rdata_q;
	row_word_t up_q, mid_q, first_q;

	logic          accept, is_access, ok;
	logic          rd_en, wr_en;
	logic [RA-1:0] rd_addr, wr_addr;
	row_word_t     wr_data, acc_word, gen_dn, gen_next;

	// Sizes in use, saturated at the grid maxima
	assign nr   = (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
	assign nc   = (32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q);
	assign ncm1 = CA'(nc - CCW'(1));

	assign accept    = start && (state_q == lats_pkg::S_IDLE);
	assign is_access = (operation == lats_pkg::OP_SET_CELL)
		|| (operation == lats_pkg::OP_CLEAR_CELL)
		|| (operation == lats_pkg::OP_READ_CELL);
	assign ok        = (row < nr) && (col < nc);

	assign busy       = (state_q != lats_pkg::S_IDLE);
	assign done       = done_q;
	assign cell_value = cell_value_q;
	assign in_range   = in_range_q;

	function automatic logic [3:0] count8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

	// Next row from the window; columns outside the sizes in use hold
	always_comb begin
		logic [MAX_COLS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
		logic [3:0] n;
		gen_dn = (state_q == lats_pkg::S_TAIL) ? first_q : rdata_q;
		for (int c = 0; c < MAX_COLS; c++) begin
			if (c == 0) begin
				up_l[c]  = up_q[ncm1];
				mid_l[c] = mid_q[ncm1];
				dn_l[c]  = gen_dn[ncm1];
			end else begin
				up_l[c]  = up_q[c-1];
				mid_l[c] = mid_q[c-1];
				dn_l[c]  = gen_dn[c-1];
			end
			if (CA'(c) == ncm1 || c == MAX_COLS - 1) begin
				up_r[c]  = up_q[0];
				mid_r[c] = mid_q[0];
				dn_r[c]  = gen_dn[0];
			end else begin
				up_r[c]  = up_q[c+1];
				mid_r[c] = mid_q[c+1];
				dn_r[c]  = gen_dn[c+1];
			end
		end
		for (int c = 0; c < MAX_COLS; c++) begin
			n = count8({up_l[c], up_q[c], up_r[c], mid_l[c], mid_r[c],
				dn_l[c], gen_dn[c], dn_r[c]});
			if (32'(c) >= 32'(nc)) begin
				gen_next[c] = mid_q[c];
			end else begin
				gen_next[c] = (n == lats_pkg::BIRTH_COUNT)
					|| ((n == lats_pkg::KEEP_COUNT) && mid_q[c]);
			end
		end
	end

	always_comb begin
		acc_word        = rdata_q;
		acc_word[col_q] = (op_q == lats_pkg::OP_SET_CELL);
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (accept && is_access && ok) begin
			rd_en   = 1'b1;
			rd_addr = RA'(row);
		end else if (state_q == lats_pkg::S_STEP) begin
			rd_en   = 1'b1;
			rd_addr = (rk_q == '0) ? RA'(nr - RCW'(1)) : RA'(rk_q - RCW'(1));
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			lats_pkg::S_INIT, lats_pkg::S_WIPE: begin
				wr_en   = 1'b1;
				wr_addr = wc_q;
			end
			lats_pkg::S_ACC: begin
				wr_en   = (op_q != lats_pkg::OP_READ_CELL);
				wr_addr = row_q;
				wr_data = acc_word;
			end
			lats_pkg::S_STEP, lats_pkg::S_LAST: begin
				// write the row whose lower neighbour has just arrived
				wr_en   = rv_s1 && (rk_s1 >= RCW'(2));
				wr_addr = RA'(rk_s1 - RCW'(2));
				wr_data = gen_next;
			end
			lats_pkg::S_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = RA'(nr - RCW'(1));
				wr_data = gen_next;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Request payload and row window
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			row_q <= RA'(row);
			col_q <= CA'(col);
		end
		if (rv_s1) begin
			up_q  <= mid_q;
			mid_q <= rdata_q;
			if (rk_s1 == RCW'(1)) begin
				first_q <= rdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lats_pkg::S_INIT;
			rows_q       <= lats_pkg::ROWS_RESET;
			cols_q       <= lats_pkg::COLS_RESET;
			wc_q         <= '0;
			rk_q         <= '0;
			rv_s1        <= 1'b0;
			rk_s1        <= '0;
			done_q       <= 1'b0;
			cell_value_q <= 1'b0;
			in_range_q   <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			cell_value_q <= 1'b0;
			in_range_q   <= 1'b0;
			rv_s1        <= (state_q == lats_pkg::S_STEP);
			rk_s1        <= rk_q;

			if (cfg_we) begin
				case (cfg_index)
					lats_pkg::REG_ROWS_IN_USE: rows_q <= cfg_data;
					lats_pkg::REG_COLS_IN_USE: cols_q <= cfg_data;
					default: rows_q <= rows_q;
				endcase
			end

			case (state_q)
				lats_pkg::S_INIT: begin
					wc_q <= wc_q + RA'(1);
					if (wc_q == LAST_ROW) begin
						state_q <= lats_pkg::S_IDLE;
					end
				end
				lats_pkg::S_IDLE: begin
					if (start) begin
						case (operation)
							lats_pkg::OP_SET_CELL, lats_pkg::OP_CLEAR_CELL,
							lats_pkg::OP_READ_CELL: begin
								if (ok) begin
									state_q <= lats_pkg::S_ACC;
								end else begin
									done_q <= 1'b1;
								end
							end
							lats_pkg::OP_STEP_GEN: begin
								if (nr == '0 || nc == '0) begin
									done_q <= 1'b1;
								end else begin
									rk_q    <= '0;
									state_q <= lats_pkg::S_STEP;
								end
							end
							lats_pkg::OP_CLEAR_GRID: begin
								wc_q    <= '0;
								state_q <= lats_pkg::S_WIPE;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				lats_pkg::S_ACC: begin
					done_q       <= 1'b1;
					in_range_q   <= 1'b1;
					cell_value_q <= (op_q == lats_pkg::OP_READ_CELL) && rdata_q[col_q];
					state_q      <= lats_pkg::S_IDLE;
				end
				lats_pkg::S_WIPE: begin
					wc_q <= wc_q + RA'(1);
					if (wc_q == LAST_ROW) begin
						done_q  <= 1'b1;
						state_q <= lats_pkg::S_IDLE;
					end
				end
				lats_pkg::S_STEP: begin
					// advance the read pointer; the wrap row is read first
					rk_q <= rk_q + RCW'(1);
					if (rk_q == nr) begin
						state_q <= lats_pkg::S_LAST;
					end
				end
				lats_pkg::S_LAST: begin
					state_q <= lats_pkg::S_TAIL;
				end
				lats_pkg::S_TAIL: begin
					done_q  <= 1'b1;
					state_q <= lats_pkg::S_IDLE;
				end
				default: begin
					state_q <= lats_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule
